>>> hw/rtl/frame_min_max_mean_with_window_average_macros.svh
// ----------------------------------------------------------------------------
// frame statistics assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef FRAME_MIN_MAX_MEAN_WITH_WINDOW_AVERAGE_MACROS_SVH
`define FRAME_MIN_MAX_MEAN_WITH_WINDOW_AVERAGE_MACROS_SVH

// same-cycle implication
`define FMMWA_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FMMWA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fmmwa_pkg.sv
// ----------------------------------------------------------------------------
// fmmwa_pkg
// types and constants shared by the frame statistics block
// ----------------------------------------------------------------------------
package fmmwa_pkg;

	localparam int SAMPLE_W = 17;
	localparam int SLOT_W   = 7;
	localparam int LEN_W    = 20;
	localparam int SUM_W    = 37;
	localparam int DIV_CNT_W = $clog2(SUM_W + 1);

	localparam int ONE_INT = 65536;
	localparam logic [SAMPLE_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [LEN_W-1:0] LEN_RESET = 20'd1024;

	localparam int HISTORY_SLOTS_DEF = 64;
	localparam int WINDOW_FIRST_DEF  = 33;
	localparam int WINDOW_SIZE_DEF   = 32;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [SLOT_W-1:0]   frame_slot;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] frame_mean;
		logic [SAMPLE_W-1:0] frame_min;
		logic [SAMPLE_W-1:0] frame_max;
		logic [SAMPLE_W-1:0] window_avg_mean;
		logic [SAMPLE_W-1:0] window_avg_min;
		logic [SAMPLE_W-1:0] window_avg_max;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [SUM_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> hw/rtl/fmmwa_div.sv
// ----------------------------------------------------------------------------
// fmmwa_div
// restoring divider, one quotient bit per cycle, SUM_W quotient bits per request
// ----------------------------------------------------------------------------
`include "frame_min_max_mean_with_window_average_macros.svh"

module fmmwa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  fmmwa_pkg::div_req_t req,
	output fmmwa_pkg::div_rsp_t rsp
);
	import fmmwa_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     dvd_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     dvs_q;

	logic [LEN_W:0]   trial;
	logic             ge;
	logic [LEN_W-1:0] rem_nx;

	assign trial  = {rem_q, dvd_q[SUM_W-1]};
	assign ge     = trial >= {1'b0, dvs_q};
	// when ge the difference is below the divisor, so it fits
	assign rem_nx = ge ? LEN_W'(trial - {1'b0, dvs_q}) : trial[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in from the bottom as dividend bits leave the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

	`FMMWA_ASSERT(a_start_when_free, req.start, !busy_q, "divider started while busy")
	`FMMWA_ASSERT_NEXT(a_start_goes_busy, req.start, busy_q, "divider did not go busy")
	`FMMWA_ASSERT(a_done_at_end, done_q, !busy_q && cnt_q == '0, "divider done too early")

endmodule

>>> hw/rtl/frame_min_max_mean_with_window_average.sv
// ----------------------------------------------------------------------------
// frame_min_max_mean_with_window_average
// per-frame min, max and mean of luminance samples with a history window
// ----------------------------------------------------------------------------
// Samples are taken one per cycle unless a frame end is held. The sample
// that ends a frame hands the frame's sum, min, max and slot to a
// statistics job and the next frame starts accumulating at once. The job
// divides the sum by the frame length in a 37-step restoring divider, then
// does a read-modify-write of the history memory and of the running window
// sums. The window averages come from the sums by a constant reciprocal
// multiply while the result register loads. Samples of the next frame are
// taken while the job runs. A frame end that arrives while the job still
// runs, or while its result still waits for the receiver, is held until
// the job is free. History is one memory with per-slot valid bits cleared
// at reset; an unwritten slot reads as zero.
// ----------------------------------------------------------------------------
`include "frame_min_max_mean_with_window_average_macros.svh"

module frame_min_max_mean_with_window_average #(
	parameter int HISTORY_SLOTS = fmmwa_pkg::HISTORY_SLOTS_DEF,
	parameter int WINDOW_FIRST  = fmmwa_pkg::WINDOW_FIRST_DEF,
	parameter int WINDOW_SIZE   = fmmwa_pkg::WINDOW_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  fmmwa_pkg::in_item_t            sample_data,
	output logic                           result_valid,
	input  logic                           result_ready,
	output fmmwa_pkg::out_item_t           result_data,
	input  logic                           cfg_we,
	input  logic [fmmwa_pkg::LEN_W-1:0]    cfg_wdata
);
	import fmmwa_pkg::*;

	localparam int IDX_W  = $clog2(HISTORY_SLOTS);
	localparam int WSUM_W = $clog2(WINDOW_SIZE * ONE_INT + 1);
	localparam int WORD_W = 3 * SAMPLE_W;

	// floor(x / WINDOW_SIZE) == (x * RECIP_M) >> RECIP_SH for every x below 2**WSUM_W
	localparam int RECIP_SH = WSUM_W + $clog2(WINDOW_SIZE);
	localparam int RECIP_W  = WSUM_W + 2;
	localparam int PROD_W   = WSUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((longint'(1) << RECIP_SH)
		+ longint'(WINDOW_SIZE) - longint'(1)) / longint'(WINDOW_SIZE));

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_DIV_MEAN = 5'b00010,
		ST_READ     = 5'b00100,
		ST_UPDATE   = 5'b01000,
		ST_OUT      = 5'b10000
	} state_t;

	state_t state_q;

	// frame accumulation
	logic [LEN_W-1:0]    len_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [LEN_W-1:0]    cnt_q;

	logic [SAMPLE_W-1:0] s_sat;
	logic [SUM_W-1:0]    sum_nx;
	logic [SAMPLE_W-1:0] min_nx;
	logic [SAMPLE_W-1:0] max_nx;
	logic [LEN_W-1:0]    cnt_nx;
	logic [LEN_W-1:0]    len_eff;
	logic                frame_end;
	logic                take;

	assign s_sat     = (sample_data.sample > ONE_Q16) ? ONE_Q16 : sample_data.sample;
	assign sum_nx    = sum_q + SUM_W'(s_sat);
	assign max_nx    = (s_sat > max_q) ? s_sat : max_q;
	assign min_nx    = (s_sat != '0 && s_sat < min_q) ? s_sat : min_q;
	assign cnt_nx    = cnt_q + LEN_W'(1);
	assign len_eff   = (len_q == '0) ? LEN_W'(1) : len_q;
	assign frame_end = (cnt_nx == '0) || (cnt_nx >= len_eff);

	// a frame end waits for the statistics job to be free
	assign sample_ready = !frame_end || state_q == ST_IDLE;
	assign take         = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
			sum_q <= '0;
			min_q <= ONE_Q16;
			max_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (take) begin
				if (frame_end) begin
					sum_q <= '0;
					min_q <= ONE_Q16;
					max_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_nx;
					min_q <= min_nx;
					max_q <= max_nx;
					cnt_q <= cnt_nx;
				end
			end
		end
	end

	// statistics job
	logic [SAMPLE_W-1:0] jmin_q;
	logic [SAMPLE_W-1:0] jmax_q;
	logic [SLOT_W-1:0]   jslot_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [WSUM_W-1:0]   wsum_q [3];
	logic [PROD_W-1:0]   wprod [3];
	logic [SAMPLE_W-1:0] wavg [3];

	always_ff @(posedge clk) begin
		if (take && frame_end) begin
			jmin_q  <= min_nx;
			jmax_q  <= max_nx;
			jslot_q <= sample_data.frame_slot;
		end
	end

	div_req_t div_req;
	div_rsp_t div_rsp;

	always_comb begin
		div_req.start    = take && frame_end;
		div_req.dividend = sum_nx;
		div_req.divisor  = len_eff;
	end

	fmmwa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// history memory: {mean, min, max} per slot
	logic [WORD_W-1:0]        hist_mem [HISTORY_SLOTS];
	logic [HISTORY_SLOTS-1:0] hvalid_q;
	logic [WORD_W-1:0]        rd_q;
	logic [WORD_W-1:0]        old_word;
	logic [IDX_W-1:0]         widx;
	logic                     slot_ok;
	logic                     in_win;
	logic                     wr_en;

	assign slot_ok  = jslot_q != '0 && 32'(jslot_q) <= HISTORY_SLOTS;
	assign in_win   = 32'(jslot_q) >= WINDOW_FIRST && 32'(jslot_q) < WINDOW_FIRST + WINDOW_SIZE;
	assign widx     = IDX_W'(32'(jslot_q) - 32'd1);
	assign wr_en    = state_q == ST_UPDATE && slot_ok;
	assign old_word = hvalid_q[widx] ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_q <= hist_mem[widx];
		end
		if (wr_en) begin
			hist_mem[widx] <= {mean_q, jmin_q, jmax_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
		end else if (wr_en) begin
			hvalid_q[widx] <= 1'b1;
		end
	end

	// running window sums, old slot value out and new one in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q[0] <= '0;
			wsum_q[1] <= '0;
			wsum_q[2] <= '0;
		end else if (wr_en && in_win) begin
			wsum_q[0] <= wsum_q[0] - WSUM_W'(old_word[WORD_W-1 -: SAMPLE_W])
				+ WSUM_W'(mean_q);
			wsum_q[1] <= wsum_q[1] - WSUM_W'(old_word[2*SAMPLE_W-1 -: SAMPLE_W])
				+ WSUM_W'(jmin_q);
			wsum_q[2] <= wsum_q[2] - WSUM_W'(old_word[SAMPLE_W-1:0])
				+ WSUM_W'(jmax_q);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wprod[k] = PROD_W'(wsum_q[k]) * PROD_W'(RECIP_M);
			wavg[k]  = wprod[k][RECIP_SH +: SAMPLE_W];
		end
	end

	// result register
	logic      result_valid_q;
	out_item_t result_data_q;
	logic      out_load;
	logic      out_in_range;

	assign out_load = state_q == ST_OUT && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_data_q.frame_mean      <= mean_q;
			result_data_q.frame_min       <= jmin_q;
			result_data_q.frame_max       <= jmax_q;
			result_data_q.window_avg_mean <= wavg[0];
			result_data_q.window_avg_min  <= wavg[1];
			result_data_q.window_avg_max  <= wavg[2];
		end
	end

	assign result_valid = result_valid_q;
	assign result_data  = result_data_q;

	// the mean is cut to 32 bits before it saturates at one
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV_MEAN && div_rsp.done) begin
			mean_q <= (div_rsp.quotient[31:0] > 32'(ONE_Q16)) ? ONE_Q16
				: div_rsp.quotient[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take && frame_end) begin
						state_q <= ST_DIV_MEAN;
					end
				end
				ST_DIV_MEAN: begin
					if (div_rsp.done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_in_range = result_data_q.window_avg_mean <= ONE_Q16
		&& result_data_q.window_avg_min <= ONE_Q16
		&& result_data_q.window_avg_max <= ONE_Q16;

	`FMMWA_ASSERT(a_frame_end_when_free, take && frame_end, state_q == ST_IDLE, "frame end busy")
	`FMMWA_ASSERT(a_div_done_expected, div_rsp.done, state_q == ST_DIV_MEAN, "stray divider result")
	`FMMWA_ASSERT_NEXT(a_out_loaded, out_load, result_valid_q && state_q == ST_IDLE, "result not loaded")
	`FMMWA_ASSERT(a_window_in_range, result_valid_q, out_in_range, "window average above one")

endmodule

>>> bench/frame_stats_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_stats_check_pkg
// expected-result tracking for the frame statistics block: follows each
// accepted sample, predicts the per-frame and window figures, compares results
// ----------------------------------------------------------------------------
package frame_stats_check_pkg;

	import fmmwa_pkg::*;

	class frame_stats_scoreboard;

		logic [LEN_W-1:0]    frame_length;
		logic [63:0]         frame_sum;
		logic [SAMPLE_W-1:0] run_min;
		logic [SAMPLE_W-1:0] run_max;
		logic [LEN_W-1:0]    sample_count;
		// index 0 mean, 1 min, 2 max
		logic [SAMPLE_W-1:0] history [3][1:HISTORY_SLOTS_DEF];
		logic [31:0]         window_sum [3];
		out_item_t           expected_frames [$];
		int                  failures;

		function new();
			frame_length = LEN_RESET;
			frame_sum    = '0;
			run_min      = ONE_Q16;
			run_max      = '0;
			sample_count = '0;
			failures     = 0;
			for (int k = 0; k < 3; k++) begin
				window_sum[k] = '0;
				for (int i = 1; i <= HISTORY_SLOTS_DEF; i++)
					history[k][i] = '0;
			end
		endfunction

		function void write_frame_length(logic [LEN_W-1:0] value);
			frame_length = value;
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10)
				$display("[%0t] %s", $realtime, msg);
		endfunction

		function void note_sample(in_item_t req);
			logic [SAMPLE_W-1:0] s;
			logic [LEN_W-1:0]    len;
			logic [63:0]         quot;
			logic [SAMPLE_W-1:0] vals [3];
			logic [31:0]         avg [3];
			out_item_t           res;
			int                  slot;

			s = (req.sample > ONE_Q16) ? ONE_Q16 : req.sample;
			frame_sum = frame_sum + 64'(s);
			if (s > run_max)
				run_max = s;
			if (s != '0 && s < run_min)
				run_min = s;
			sample_count = sample_count + 1'b1;
			len = (frame_length == '0) ? LEN_W'(1) : frame_length;
			// frame ends once the count reaches the length, even if it was lowered
			if (sample_count != '0 && sample_count < len)
				return;

			// the mean is cut to 32 bits before it saturates at one
			quot = frame_sum / 64'(len);
			vals[0] = (quot[31:0] > 32'(ONE_INT)) ? ONE_Q16 : quot[SAMPLE_W-1:0];
			vals[1] = run_min;
			vals[2] = run_max;
			slot = int'(req.frame_slot);
			if (slot >= 1 && slot <= HISTORY_SLOTS_DEF) begin
				for (int k = 0; k < 3; k++) begin
					if (slot >= WINDOW_FIRST_DEF && slot < WINDOW_FIRST_DEF + WINDOW_SIZE_DEF)
						window_sum[k] = window_sum[k] - 32'(history[k][slot]) + 32'(vals[k]);
					history[k][slot] = vals[k];
				end
			end
			for (int k = 0; k < 3; k++)
				avg[k] = window_sum[k] / 32'(WINDOW_SIZE_DEF);

			res.frame_mean      = vals[0];
			res.frame_min       = vals[1];
			res.frame_max       = vals[2];
			res.window_avg_mean = avg[0][SAMPLE_W-1:0];
			res.window_avg_min  = avg[1][SAMPLE_W-1:0];
			res.window_avg_max  = avg[2][SAMPLE_W-1:0];
			expected_frames.push_back(res);

			frame_sum    = '0;
			run_min      = ONE_Q16;
			run_max      = '0;
			sample_count = '0;
		endfunction

		function void check_result(out_item_t got);
			out_item_t           want;
			logic [SAMPLE_W-1:0] w [6];
			logic [SAMPLE_W-1:0] g [6];
			string               names [6];

			names = '{"frame_mean", "frame_min", "frame_max",
				"window_avg_mean", "window_avg_min", "window_avg_max"};
			if (expected_frames.size() == 0) begin
				flag("result arrived with no frame pending");
				return;
			end
			want = expected_frames.pop_front();
			w = '{want.frame_mean, want.frame_min, want.frame_max,
				want.window_avg_mean, want.window_avg_min, want.window_avg_max};
			g = '{got.frame_mean, got.frame_min, got.frame_max,
				got.window_avg_mean, got.window_avg_min, got.window_avg_max};
			for (int i = 0; i < 6; i++) begin
				if (w[i] !== g[i])
					flag($sformatf("result field %s: expected %0d, got %0d",
						names[i], w[i], g[i]));
			end
		endfunction

	endclass

endpackage

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives samples and frame lengths into the frame statistics block under
// varying sender gaps and receiver stalls, and checks every frame result
// ----------------------------------------------------------------------------
module testbench;

	import fmmwa_pkg::*;
	import frame_stats_check_pkg::*;

	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 3000;
	localparam int PHASES       = 8;

	logic             clk;
	logic             arst_n;
	logic             sample_valid;
	logic             sample_ready;
	in_item_t         sample_data;
	logic             result_valid;
	logic             result_ready;
	out_item_t        result_data;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;

	frame_stats_scoreboard sb;

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_requests;
	int holds_served;

	int phase_len   [PHASES] = '{1, 5, 1, 2, 1, 200, 0, 0};
	int phase_items [PHASES] = '{150, 150, 120, 150, 60, 200, 150, 80};
	int phase_tx    [PHASES] = '{0, 63, 0, 12, 0, 0, 12, 63};
	int phase_rx    [PHASES] = '{0, 0, 63, 12, 0, 0, 12, 0};

	frame_min_max_mean_with_window_average u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_frame_length(cfg_wdata);
			if (sample_valid && sample_ready)
				sb.note_sample(sample_data);
			if (result_valid && result_ready)
				sb.check_result(result_data);
		end
	end

	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && sample_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("frame_min_max_mean_with_window_average: mismatch");
		$finish;
	end

	task automatic send_request(input in_item_t req);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_data  <= req;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
	endtask

	// drop valid, let every frame result drain and the last job finish
	task automatic settle();
		sample_valid <= 1'b0;
		// the last accepted request is noted by the monitor at that edge
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_frame_length(input logic [LEN_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic in_item_t random_request();
		in_item_t r;
		case ($urandom_range(0, 9))
			0: r.sample = '0;
			1: r.sample = ONE_Q16;
			2: r.sample = SAMPLE_W'($urandom_range(65537, 131071));
			3: r.sample = SAMPLE_W'($urandom_range(1, 15));
			default: r.sample = SAMPLE_W'($urandom_range(0, 65536));
		endcase
		// mostly window slots so the running sums keep moving
		case ($urandom_range(0, 19))
			0, 1: r.frame_slot = SLOT_W'($urandom_range(65, 127));
			2: r.frame_slot = '0;
			3, 4, 5, 6: r.frame_slot = SLOT_W'($urandom_range(1, 32));
			default: r.frame_slot = SLOT_W'($urandom_range(33, 64));
		endcase
		return r;
	endfunction

	initial begin
		sb            = new();
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		hold_requests = 0;
		holds_served  = 0;
		arst_n       <= 1'b0;
		sample_valid <= 1'b0;
		sample_data  <= '0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero length acts as one: every sample closes a frame
		program_frame_length('0);
		send_request('{17'd0, 7'd33});
		send_request('{17'h10000, 7'd64});
		send_request('{17'h1FFFF, 7'd40});
		send_request('{17'd1, 7'd0});
		send_request('{17'd5, 7'd65});
		send_request('{17'd7, 7'd127});
		send_request('{17'd100, 7'd1});
		settle();

		program_frame_length(20'd3);
		send_request('{17'd0, 7'd33});
		send_request('{17'd0, 7'd33});
		send_request('{17'd0, 7'd33});
		send_request('{17'h10000, 7'd34});
		send_request('{17'h10000, 7'd34});
		send_request('{17'h10000, 7'd34});
		send_request('{17'd1, 7'd50});
		send_request('{17'h1FFFF, 7'd50});
		send_request('{17'd0, 7'd50});
		settle();

		// longest frame, then cut short while part of it is accumulated
		program_frame_length('1);
		send_request('{17'd1000, 7'd35});
		send_request('{17'd20000, 7'd35});
		send_request('{17'h10000, 7'd35});
		settle();
		program_frame_length(20'd2);
		send_request('{17'd9, 7'd35});
		settle();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 6)
				program_frame_length(LEN_W'($urandom_range(1, 12)));
			else
				program_frame_length(LEN_W'(phase_len[p]));
			tx_idle_pct  = phase_tx[p];
			rx_stall_pct = phase_rx[p];
			// long receiver hold while requests keep coming
			if (p == 4)
				hold_requests++;
			for (int i = 0; i < phase_items[p]; i++)
				send_request(random_request());
			settle();
		end

		if (sb.failures == 0 && sb.pending() == 0)
			$display("frame_min_max_mean_with_window_average: match");
		else
			$display("frame_min_max_mean_with_window_average: mismatch");
		$finish;
	end

endmodule
